@@ rtl/core/dmd_pkg.sv @@
// Package for the delimited message deframer: widths, limits and state codes.
// No dependencies; dmd_if.sv and delimited_message_deframer.sv use it by scoped names.
`default_nettype none

package dmd_pkg;

    // Message store size in bytes; one message holds at most MESSAGE_BYTES-1 bytes
    localparam int MESSAGE_BYTES = 64;
    localparam int BYTE_W        = 8;
    localparam int FILL_W        = $clog2(MESSAGE_BYTES);

    localparam logic [FILL_W-1:0] FILL_MAX         = FILL_W'(MESSAGE_BYTES - 1);
    localparam logic [BYTE_W-1:0] END_MARKER_RESET = BYTE_W'(10);
    localparam logic [BYTE_W-1:0] NULL_BYTE        = '0;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [FILL_W-1:0] fill_t;

    typedef enum logic
    {
        ST_FILL,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/dmd_if.sv @@
// Handshake channel interfaces of the deframer: received byte, message byte, config.
// Depends on dmd_pkg for the byte type.
`default_nettype none

interface dmd_rx_if;
    logic           valid;
    logic           ready;
    dmd_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dmd_msg_if;
    logic           valid;
    logic           ready;
    dmd_pkg::byte_t msg_byte;
    logic           last_byte;

    modport source (output valid, output msg_byte, output last_byte, input ready);
    modport sink   (input valid, input msg_byte, input last_byte, output ready);
endinterface

interface dmd_cfg_if;
    logic           valid;
    logic           ready;
    dmd_pkg::byte_t end_marker;

    modport source (output valid, output end_marker, input ready);
    modport sink   (input valid, input end_marker, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dmd_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module dmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/delimited_message_deframer.sv @@
// Top level of the delimited message deframer: message store RAM and its controller.
// Depends on dmd_pkg, the interfaces in dmd_if.sv and dmd_ram.
//
// Usage:
//   rx  : one received byte per word. Zero bytes are ignored. Data bytes are
//         written into the message store, one per cycle outside a drain. A
//         byte equal to the end marker with a non-empty store drains the message.
//   msg : the stored message, one byte per word, last_byte set on its final byte.
//   cfg : writes the end marker; ready is always high. Write only while idle.
// Throughput: one received byte per cycle while filling. While a message drains,
// rx is held off; each message byte needs a store read and then a load of the
// output register before the next read, so rx stays blocked for the whole drain.
// After the end marker, the first byte passes the drain state, the store read
// and the output register. A message of MESSAGE_BYTES-1 bytes followed by
// another data byte is discarded without output.
// Reset: store empty, end marker 10. The store needs no clearing; only written
// entries are read. When msg stalls, the drain pauses and the output word holds.
`default_nettype none

module delimited_message_deframer (
    input wire logic clk,
    input wire logic rst_n,
    dmd_cfg_if.sink  cfg,
    dmd_rx_if.sink   rx,
    dmd_msg_if.source msg
);

    dmd_pkg::state_t state_reg, state_next;
    dmd_pkg::fill_t  fill_reg, fill_next;
    dmd_pkg::fill_t  drain_len_reg, drain_len_next;
    dmd_pkg::fill_t  rd_idx_reg, rd_idx_next;
    dmd_pkg::byte_t  end_marker_reg;
    logic            rd_pend_reg, rd_pend_next;
    logic            rd_last_reg, rd_last_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_last_reg;
    dmd_pkg::byte_t  out_byte_reg;

    logic            rx_take;
    logic            is_marker;
    logic            is_null;
    logic            ram_we;
    logic            ram_re;
    logic            rd_is_last;
    logic            out_free;
    dmd_pkg::byte_t  ram_rdata;

    assign cfg.ready = 1'b1;
    assign rx.ready  = (state_reg == dmd_pkg::ST_FILL);
    assign rx_take   = rx.valid && rx.ready;
    assign is_null   = (rx.rx_byte == dmd_pkg::NULL_BYTE);
    assign is_marker = (rx.rx_byte == end_marker_reg);

    assign msg.valid     = out_valid_reg;
    assign msg.msg_byte  = out_byte_reg;
    assign msg.last_byte = out_last_reg;

    // Output register is free this cycle if empty or being taken
    assign out_free   = !out_valid_reg || msg.ready;
    assign rd_is_last = (rd_idx_reg == drain_len_reg - dmd_pkg::fill_t'(1));

    // Store write: data bytes below the full limit
    assign ram_we = rx_take && !is_null && !is_marker && (fill_reg != dmd_pkg::FILL_MAX);
    // Store read: one at a time, only when the output word can be loaded next cycle
    assign ram_re = (state_reg == dmd_pkg::ST_DRAIN) && !rd_pend_reg && out_free;

    dmd_ram #(
        .WIDTH (dmd_pkg::BYTE_W),
        .DEPTH (dmd_pkg::MESSAGE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg),
        .wdata (rx.rx_byte),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Hold the end marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_marker_reg <= dmd_pkg::END_MARKER_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            end_marker_reg <= cfg.end_marker;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmd_pkg::ST_FILL;
            fill_reg      <= '0;
            drain_len_reg <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            drain_len_reg <= drain_len_next;
            rd_idx_reg    <= rd_idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output word when store data returns
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            out_byte_reg <= ram_rdata;
            out_last_reg <= rd_last_reg;
        end
    end

    // Next state: gather bytes, then drain the store
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        drain_len_next = drain_len_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = ram_re;
        rd_last_next   = rd_is_last;
        out_valid_next = out_valid_reg;

        if (msg.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            dmd_pkg::ST_FILL:
            begin
                if (rx_take && !is_null)
                begin
                    if (is_marker)
                    begin
                        // Start a drain unless the store is empty
                        if (fill_reg != '0)
                        begin
                            state_next     = dmd_pkg::ST_DRAIN;
                            drain_len_next = fill_reg;
                            rd_idx_next    = '0;
                            fill_next      = '0;
                        end
                    end
                    else if (fill_reg == dmd_pkg::FILL_MAX)
                    begin
                        // Drop the partial message
                        fill_next = '0;
                    end
                    else
                    begin
                        fill_next = fill_reg + dmd_pkg::fill_t'(1);
                    end
                end
            end
            dmd_pkg::ST_DRAIN:
            begin
                if (ram_re)
                begin
                    rd_idx_next = rd_idx_reg + dmd_pkg::fill_t'(1);
                    if (rd_is_last)
                    begin
                        state_next = dmd_pkg::ST_FILL;
                    end
                end
            end
            default:
            begin
                state_next = dmd_pkg::ST_FILL;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A pending read always finds the output register empty
    a_pend_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !out_valid_reg)
        else $error("store read returned while output word still held");

    // A pending read loads the output word on the next cycle
    a_pend_loads: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |=> out_valid_reg)
        else $error("store read data lost");

    // The drain read index stays inside the message
    a_drain_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmd_pkg::ST_DRAIN) |-> (rd_idx_reg < drain_len_reg))
        else $error("drain read index past message end");

    // Store never written during a drain
    a_no_write_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmd_pkg::ST_DRAIN) |-> !ram_we)
        else $error("store written while draining");
`endif

endmodule

`default_nettype wire
